// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define CFMW_ASSERT(lbl, clk_s, rst_n_s, prop, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (prop)) else $error(msg);

// Checked on every rising edge at which reset is held.
`define CFMW_ASSERT_IN_RST(lbl, clk_s, rst_n_s, prop, msg) \
	lbl: assert property (@(posedge clk_s) (!rst_n_s) |-> (prop)) else $error(msg);

`endif

// ===== design/cfmw_pkg.sv =====
// Constants, register codes and arithmetic helpers of the crossfader weight unit.
`default_nettype none
package cfmw_pkg;

	localparam logic [1:0] LAW_SMOOTH = 2'd0;
	localparam logic [1:0] LAW_LINEAR = 2'd1;
	localparam logic [1:0] LAW_SHARP  = 2'd2;
	localparam logic [1:0] LAW_CUT    = 2'd3;

	localparam logic [2:0] REG_XFADER_LAW    = 3'd0;
	localparam logic [2:0] REG_CHAN_A_LAW    = 3'd1;
	localparam logic [2:0] REG_CHAN_B_LAW    = 3'd2;
	localparam logic [2:0] REG_XFADER_INVERT = 3'd3;
	localparam logic [2:0] REG_CHAN_A_INVERT = 3'd4;
	localparam logic [2:0] REG_CHAN_B_INVERT = 3'd5;
	localparam logic [2:0] REG_OVERLAY_ON    = 3'd6;
	localparam logic [2:0] REG_OVERLAY_LEVEL = 3'd7;

	localparam logic [15:0] Q16_ONE     = 16'hFFFF;
	localparam logic [15:0] Q16_HALF_LO = 16'h7FFF;
	localparam longint      HALF_PI_Q30 = 64'sd1686629713;
	localparam logic [21:0] SHARP_SLOPE = 22'd50;

	// (2n)(2n+1) for the odd Taylor terms n = 1..6
	localparam longint TAYLOR_DIV [1:6] = '{64'sd6, 64'sd20, 64'sd42, 64'sd72, 64'sd110, 64'sd156};

	// Floor of v / 65535, valid while (v mod 2^16) + (v >> 16) < 2 * 65535,
	// which holds for every value this unit feeds it.
	function automatic logic [15:0] div65535(input logic [31:0] v);
		logic [15:0] q0;
		logic [17:0] r0;
		q0 = v[31:16];
		r0 = {2'b00, v[15:0]} + {2'b00, q0};
		return (r0 >= {2'b00, Q16_ONE}) ? q0 + 16'd1 : q0;
	endfunction

	// 2% knee: slope of 50, saturating at full scale
	function automatic logic [15:0] sharp_ramp(input logic [15:0] d);
		logic [21:0] v;
		v = {6'd0, d} * SHARP_SLOPE;
		return (v > {6'd0, Q16_ONE}) ? Q16_ONE : v[15:0];
	endfunction

	// Quarter-wave entry k of a table with 2^abits steps, Q30 Taylor series.
	// Evaluated at elaboration only.
	function automatic logic [15:0] sine_entry(input int unsigned k, input int unsigned abits);
		longint a;
		longint term;
		longint sum;
		longint v;
		a = (longint'(k) * HALF_PI_Q30) >>> abits;
		term = a;
		sum = a;
		for (int n = 1; n <= 6; n++) begin
			term = (term * a) >>> 30;
			term = (term * a) >>> 30;
			term = term / TAYLOR_DIV[n];
			if ((n & 1) != 0) begin
				sum = sum - term;
			end else begin
				sum = sum + term;
			end
		end
		if (sum < 0) begin
			sum = 0;
		end
		v = (sum * 64'sd65535 + (64'sd1 <<< 29)) >>> 30;
		if (v > 64'sd65535) begin
			v = 64'sd65535;
		end
		return v[15:0];
	endfunction

endpackage
`default_nettype wire

// ===== design/cfmw_sine_rom.sv =====
// Quarter-wave sine ROM with two registered read ports.
`default_nettype none
module cfmw_sine_rom #(
	parameter int ADDR_BITS = 10
) (
	input  wire logic                 clk,
	input  wire logic                 en,
	input  wire logic [ADDR_BITS:0]   addr0,
	input  wire logic [ADDR_BITS:0]   addr1,
	output logic      [15:0]          data0,
	output logic      [15:0]          data1
);

	localparam int DEPTH = (1 << ADDR_BITS) + 1;

	typedef logic [15:0] rom_t [DEPTH];

	function automatic rom_t build_rom();
		rom_t r;
		for (int k = 0; k < DEPTH; k++) begin
			r[k] = cfmw_pkg::sine_entry(k, ADDR_BITS);
		end
		return r;
	endfunction

	localparam rom_t ROM = build_rom();

	logic [15:0] data0_q;
	logic [15:0] data1_q;

	always_ff @(posedge clk) begin
		if (en) begin
			data0_q <= ROM[addr0];
			data1_q <= ROM[addr1];
		end
	end

	assign data0 = data0_q;
	assign data1 = data1_q;

endmodule
`default_nettype wire

// ===== design/crossfader_mix_weights_unit.sv =====
// Four register stages; one item per cycle while result_stall does not hold the pipeline.
// Stages: invert/index/ramp, sine ROM read and law select, smooth select and 16x16 multiply,
// divide by 65535. Each stage holds only while the stage after it is full and stalled.
// Reset (arst_n low, asynchronous) empties the pipeline and loads register defaults:
// all laws linear, no inversion, overlay off with level zero. The sine ROM is constant.
`default_nettype none
module crossfader_mix_weights_unit #(
	parameter int SINE_TABLE_ADDR_BITS = 10
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	input  wire logic        item_valid,
	output logic             item_stall,
	input  wire logic [15:0] xfader_pos,
	input  wire logic [15:0] fader_a_pos,
	input  wire logic [15:0] fader_b_pos,
	output logic             result_valid,
	input  wire logic        result_stall,
	output logic      [15:0] weight_a,
	output logic      [15:0] weight_b,
	output logic      [15:0] weight_overlay
);

	localparam int IDX_W = SINE_TABLE_ADDR_BITS + 1;
	localparam logic [IDX_W-1:0] TAB_N = IDX_W'(1) << SINE_TABLE_ADDR_BITS;

	// configuration registers
	logic [1:0]  xfader_law_q;
	logic [1:0]  chan_a_law_q;
	logic [1:0]  chan_b_law_q;
	logic        xfader_invert_q;
	logic        chan_a_invert_q;
	logic        chan_b_invert_q;
	logic        overlay_on_q;
	logic [15:0] overlay_level_q;

	logic cfg_wr;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xfader_law_q    <= cfmw_pkg::LAW_LINEAR;
			chan_a_law_q    <= cfmw_pkg::LAW_LINEAR;
			chan_b_law_q    <= cfmw_pkg::LAW_LINEAR;
			xfader_invert_q <= 1'b0;
			chan_a_invert_q <= 1'b0;
			chan_b_invert_q <= 1'b0;
			overlay_on_q    <= 1'b0;
			overlay_level_q <= 16'd0;
		end else if (cfg_wr) begin
			case (paddr[4:2])
				cfmw_pkg::REG_XFADER_LAW:    xfader_law_q    <= pwdata[1:0];
				cfmw_pkg::REG_CHAN_A_LAW:    chan_a_law_q    <= pwdata[1:0];
				cfmw_pkg::REG_CHAN_B_LAW:    chan_b_law_q    <= pwdata[1:0];
				cfmw_pkg::REG_XFADER_INVERT: xfader_invert_q <= pwdata[0];
				cfmw_pkg::REG_CHAN_A_INVERT: chan_a_invert_q <= pwdata[0];
				cfmw_pkg::REG_CHAN_B_INVERT: chan_b_invert_q <= pwdata[0];
				cfmw_pkg::REG_OVERLAY_ON:    overlay_on_q    <= pwdata[0];
				cfmw_pkg::REG_OVERLAY_LEVEL: overlay_level_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			cfmw_pkg::REG_XFADER_LAW:    prdata = {30'd0, xfader_law_q};
			cfmw_pkg::REG_CHAN_A_LAW:    prdata = {30'd0, chan_a_law_q};
			cfmw_pkg::REG_CHAN_B_LAW:    prdata = {30'd0, chan_b_law_q};
			cfmw_pkg::REG_XFADER_INVERT: prdata = {31'd0, xfader_invert_q};
			cfmw_pkg::REG_CHAN_A_INVERT: prdata = {31'd0, chan_a_invert_q};
			cfmw_pkg::REG_CHAN_B_INVERT: prdata = {31'd0, chan_b_invert_q};
			cfmw_pkg::REG_OVERLAY_ON:    prdata = {31'd0, overlay_on_q};
			cfmw_pkg::REG_OVERLAY_LEVEL: prdata = {16'd0, overlay_level_q};
			default:                     prdata = 32'd0;
		endcase
	end

	// stage enables: a stage moves when empty or when the next one moves
	logic v_s1, v_s2, v_s3, v_s4;
	logic en1, en2, en3, en4;

	assign en4 = !v_s4 || !result_stall;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign item_stall = !en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= item_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	// stage 1: inversion, table index, sharp ramps
	logic [15:0] x_i, fa_i, fb_i;
	logic [31:0] vx, vfa, vfb;
	logic [15:0] qx, qfa, qfb;

	assign x_i  = xfader_invert_q ? ~xfader_pos  : xfader_pos;
	assign fa_i = chan_a_invert_q ? ~fader_a_pos : fader_a_pos;
	assign fb_i = chan_b_invert_q ? ~fader_b_pos : fader_b_pos;

	assign vx  = 32'({x_i,  {SINE_TABLE_ADDR_BITS{1'b0}}}) + {16'd0, cfmw_pkg::Q16_HALF_LO};
	assign vfa = 32'({fa_i, {SINE_TABLE_ADDR_BITS{1'b0}}}) + {16'd0, cfmw_pkg::Q16_HALF_LO};
	assign vfb = 32'({fb_i, {SINE_TABLE_ADDR_BITS{1'b0}}}) + {16'd0, cfmw_pkg::Q16_HALF_LO};
	assign qx  = cfmw_pkg::div65535(vx);
	assign qfa = cfmw_pkg::div65535(vfa);
	assign qfb = cfmw_pkg::div65535(vfb);

	logic [15:0]      x_s1, fa_s1, fb_s1;
	logic [15:0]      shx_a_s1, shx_b_s1, sh_fa_s1, sh_fb_s1;
	logic [IDX_W-1:0] idx_x_s1, idx_fa_s1, idx_fb_s1;

	always_ff @(posedge clk) begin
		if (en1) begin
			x_s1      <= x_i;
			fa_s1     <= fa_i;
			fb_s1     <= fb_i;
			shx_a_s1  <= cfmw_pkg::sharp_ramp(~x_i);
			shx_b_s1  <= cfmw_pkg::sharp_ramp(x_i);
			sh_fa_s1  <= cfmw_pkg::sharp_ramp(fa_i);
			sh_fb_s1  <= cfmw_pkg::sharp_ramp(fb_i);
			idx_x_s1  <= qx[IDX_W-1:0];
			idx_fa_s1 <= qfa[IDX_W-1:0];
			idx_fb_s1 <= qfb[IDX_W-1:0];
		end
	end

	// stage 2: sine reads (cos taken from the mirrored index) and non-smooth laws
	logic [15:0] sin_x_s2, cos_x_s2, sin_fa_s2, sin_fb_s2;
	logic [IDX_W-1:0] idx_xc;

	assign idx_xc = TAB_N - idx_x_s1;

	cfmw_sine_rom #(
		.ADDR_BITS (SINE_TABLE_ADDR_BITS)
	) u_rom_xfader (
		.clk   (clk),
		.en    (en2),
		.addr0 (idx_x_s1),
		.addr1 (idx_xc),
		.data0 (sin_x_s2),
		.data1 (cos_x_s2)
	);

	cfmw_sine_rom #(
		.ADDR_BITS (SINE_TABLE_ADDR_BITS)
	) u_rom_chan (
		.clk   (clk),
		.en    (en2),
		.addr0 (idx_fa_s1),
		.addr1 (idx_fb_s1),
		.data0 (sin_fa_s2),
		.data1 (sin_fb_s2)
	);

	logic [15:0] wa_n, wb_n, ga_n, gb_n;

	always_comb begin
		case (xfader_law_q)
			cfmw_pkg::LAW_SHARP: begin
				wa_n = shx_a_s1;
				wb_n = shx_b_s1;
			end
			cfmw_pkg::LAW_CUT: begin
				wa_n = x_s1[15] ? 16'd0 : cfmw_pkg::Q16_ONE;
				wb_n = x_s1[15] ? cfmw_pkg::Q16_ONE : 16'd0;
			end
			default: begin
				wa_n = ~x_s1;
				wb_n = x_s1;
			end
		endcase
		case (chan_a_law_q)
			cfmw_pkg::LAW_SHARP: ga_n = sh_fa_s1;
			cfmw_pkg::LAW_CUT:   ga_n = fa_s1[15] ? cfmw_pkg::Q16_ONE : 16'd0;
			default:             ga_n = fa_s1;
		endcase
		case (chan_b_law_q)
			cfmw_pkg::LAW_SHARP: gb_n = sh_fb_s1;
			cfmw_pkg::LAW_CUT:   gb_n = fb_s1[15] ? cfmw_pkg::Q16_ONE : 16'd0;
			default:             gb_n = fb_s1;
		endcase
	end

	logic [15:0] wa_s2, wb_s2, ga_s2, gb_s2;

	always_ff @(posedge clk) begin
		if (en2) begin
			wa_s2 <= wa_n;
			wb_s2 <= wb_n;
			ga_s2 <= ga_n;
			gb_s2 <= gb_n;
		end
	end

	// stage 3: smooth override and weight times gain, with rounding offset
	logic [15:0] wa_m, wb_m, ga_m, gb_m;

	assign wa_m = (xfader_law_q == cfmw_pkg::LAW_SMOOTH) ? cos_x_s2  : wa_s2;
	assign wb_m = (xfader_law_q == cfmw_pkg::LAW_SMOOTH) ? sin_x_s2  : wb_s2;
	assign ga_m = (chan_a_law_q == cfmw_pkg::LAW_SMOOTH) ? sin_fa_s2 : ga_s2;
	assign gb_m = (chan_b_law_q == cfmw_pkg::LAW_SMOOTH) ? sin_fb_s2 : gb_s2;

	logic [31:0] prod_a_s3, prod_b_s3;

	always_ff @(posedge clk) begin
		if (en3) begin
			prod_a_s3 <= ({16'd0, wa_m} * {16'd0, ga_m}) + {16'd0, cfmw_pkg::Q16_HALF_LO};
			prod_b_s3 <= ({16'd0, wb_m} * {16'd0, gb_m}) + {16'd0, cfmw_pkg::Q16_HALF_LO};
		end
	end

	// stage 4: back to Q0.16, output register
	logic [15:0] weight_a_s4, weight_b_s4, weight_ovl_s4;

	always_ff @(posedge clk) begin
		if (en4) begin
			weight_a_s4   <= cfmw_pkg::div65535(prod_a_s3);
			weight_b_s4   <= cfmw_pkg::div65535(prod_b_s3);
			weight_ovl_s4 <= overlay_on_q ? overlay_level_q : 16'd0;
		end
	end

	assign result_valid   = v_s4;
	assign weight_a       = weight_a_s4;
	assign weight_b       = weight_b_s4;
	assign weight_overlay = weight_ovl_s4;

endmodule
`default_nettype wire

// ===== design/cfmw_checker.sv =====
// Port-level checks on the crossfader weight unit, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module cfmw_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        item_stall,
	input wire logic        result_valid,
	input wire logic        result_stall,
	input wire logic [15:0] weight_a,
	input wire logic [15:0] weight_b,
	input wire logic [15:0] weight_overlay
);

	// pipeline is empty in reset, so nothing is shown and nothing is held off
	`CFMW_ASSERT_IN_RST(a_rst_no_result, clk, arst_n, !result_valid, "result valid in reset")
	`CFMW_ASSERT_IN_RST(a_rst_no_stall, clk, arst_n, !item_stall, "item stall in reset")

	// the input only backs up when the output register is full and stalled
	`CFMW_ASSERT(a_stall_cause, clk, arst_n, item_stall |-> (result_valid && result_stall), "input stalled with output free")

	`CFMW_ASSERT(a_result_hold, clk, arst_n, (result_valid && result_stall) |=> (result_valid && $stable(weight_a) && $stable(weight_b) && $stable(weight_overlay)), "stalled result changed")

endmodule

bind crossfader_mix_weights_unit cfmw_checker u_cfmw_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.item_stall     (item_stall),
	.result_valid   (result_valid),
	.result_stall   (result_stall),
	.weight_a       (weight_a),
	.weight_b       (weight_b),
	.weight_overlay (weight_overlay)
);
`default_nettype wire
